// ===== hw/rtl/two_class_priority_job_queue_top_assert.svh =====
// Assertion macros shared by the job queue RTL.
`ifndef TWO_CLASS_PRIORITY_JOB_QUEUE_TOP_ASSERT_SVH
`define TWO_CLASS_PRIORITY_JOB_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst is high.
`define TCPQ_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst is high.
`define TCPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tcpq_pkg.sv =====
// Field widths, stream packing and operation and status codes of the job queue.
package tcpq_pkg;

  localparam int KIND_W     = 2;
  localparam int JOB_ID_W   = 16;
  localparam int PAGES_W    = 16;
  localparam int STATUS_W   = 3;

  // Stream widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 8;

  localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SERVE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

endpackage

// ===== hw/rtl/tcpq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module tcpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/two_class_priority_job_queue_top.sv =====
// Two-class strict-priority job queue: top level with its control sequencer.
//
// Requests enter on the s_ stream: s_tuser holds the operation (enqueue,
// serve, cancel, lookup) and s_tdata the job id, page count and class.
// Each request gives exactly one item on the m_ stream: m_tuser holds the
// status and m_tdata the reported id, page count and source class.
// The block works on one request at a time; s_tready is low while it does.
// A single compare unit scans the queues one entry per cycle, each from
// its own RAM with a registered read, and removal shifts later entries down
// one per cycle through the same read port. An enqueue scans both queues for
// a duplicate, a serve shifts the served queue, a cancel scans the queues
// and shifts the one it hits, and a lookup scans the queues until it hits.
// The result waits in an output register; the next request is accepted
// while it waits, but its own result holds until m_tready takes the first.
// A synchronous reset empties both queues at once and drops a pending
// result; the RAM contents are left as they are and never read unwritten.
`include "two_class_priority_job_queue_top_assert.svh"

module two_class_priority_job_queue_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // job_id [15:0], page_count [31:16], is_priority [32], zero above
  input  logic [tcpq_pkg::IN_DATA_W-1:0]  s_tdata,
  // kind [1:0], zero above
  input  logic [tcpq_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_id [15:0], out_pages [31:16], from_priority [32], zero above
  output logic [tcpq_pkg::OUT_DATA_W-1:0] m_tdata,
  // status [2:0], zero above
  output logic [tcpq_pkg::OUT_USER_W-1:0] m_tuser
);

  import tcpq_pkg::*;

  localparam int IDW     = (ID_BITS < JOB_ID_W) ? ID_BITS : JOB_ID_W;
  localparam int ENTRY_W = PAGES_W + IDW;
  localparam int AW      = $clog2(QUEUE_DEPTH);
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_SERVE_RD  = 3'd2;
  localparam logic [2:0] S_SERVE_CAP = 3'd3;
  localparam logic [2:0] S_SHIFT     = 3'd4;
  localparam logic [2:0] S_DONE      = 3'd5;

  logic [2:0]          state;
  logic [CW-1:0]       prio_fill;
  logic [CW-1:0]       norm_fill;

  logic [KIND_W-1:0]   op_kind;
  logic [IDW-1:0]      key;
  logic [PAGES_W-1:0]  op_pages;
  logic                op_prio;

  // q selects the queue under work: 1 priority, 0 normal.
  logic                q;
  logic                second;
  logic [CW-1:0]       idx;
  logic                pend_valid;
  logic [AW-1:0]       pend_idx;

  logic [STATUS_W-1:0] res_status;
  logic [JOB_ID_W-1:0] res_id;
  logic [PAGES_W-1:0]  res_pages;
  logic                res_fp;

  logic [ENTRY_W-1:0]  rd_p;
  logic [ENTRY_W-1:0]  rd_n;
  logic [ENTRY_W-1:0]  rd_entry;
  logic [IDW-1:0]      rd_id;
  logic [PAGES_W-1:0]  rd_pages;
  logic [CW-1:0]       cur_fill;
  logic [CW-1:0]       tgt_fill;
  logic                hit;
  logic                idx_live;
  logic                scan_end;
  logic                enq_ok;
  logic                in_accept;

  logic                we_p;
  logic                we_n;
  logic [AW-1:0]       wr_addr;
  logic [ENTRY_W-1:0]  wr_data;

  assign cur_fill  = q ? prio_fill : norm_fill;
  assign tgt_fill  = op_prio ? prio_fill : norm_fill;
  assign rd_entry  = q ? rd_p : rd_n;
  assign rd_id     = rd_entry[IDW-1:0];
  assign rd_pages  = rd_entry[ENTRY_W-1:IDW];
  assign hit       = pend_valid && (rd_id == key);
  assign idx_live  = idx < cur_fill;
  assign scan_end  = (state == S_SCAN) && !hit && !idx_live;
  assign enq_ok    = (op_pages != '0) && (tgt_fill != DEPTH_C);
  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;

  // Write port: a shifted entry moves down one place, or a new job lands at the tail.
  always_comb begin
    we_p    = 1'b0;
    we_n    = 1'b0;
    wr_addr = pend_idx - 1'b1;
    wr_data = rd_entry;
    if (state == S_SHIFT && pend_valid) begin
      we_p = q;
      we_n = !q;
    end else if (scan_end && second && op_kind == KIND_ENQUEUE && enq_ok) begin
      wr_addr = tgt_fill[AW-1:0];
      wr_data = {op_pages, key};
      we_p    = op_prio;
      we_n    = !op_prio;
    end
  end

  tcpq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_prio_ram (
    .clk   (clk),
    .we    (we_p),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (idx[AW-1:0]),
    .rdata (rd_p)
  );

  tcpq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_norm_ram (
    .clk   (clk),
    .we    (we_n),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (idx[AW-1:0]),
    .rdata (rd_n)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prio_fill  <= '0;
      norm_fill  <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // In S_DONE the output register is handled by the state itself.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            op_kind    <= s_tuser[KIND_W-1:0];
            key        <= s_tdata[IDW-1:0];
            op_pages   <= s_tdata[JOB_ID_W +: PAGES_W];
            op_prio    <= s_tdata[JOB_ID_W + PAGES_W];
            idx        <= '0;
            pend_valid <= 1'b0;
            second     <= 1'b0;
            res_id     <= '0;
            res_pages  <= '0;
            res_fp     <= 1'b0;
            case (s_tuser[KIND_W-1:0])
              KIND_ENQUEUE: begin
                if (s_tdata[IDW-1:0] == '0) begin
                  res_status <= ST_INVALID;
                  state      <= S_DONE;
                end else begin
                  q     <= 1'b1;
                  state <= S_SCAN;
                end
              end
              KIND_SERVE: begin
                if (prio_fill != '0) begin
                  q     <= 1'b1;
                  state <= S_SERVE_RD;
                end else if (norm_fill != '0) begin
                  q     <= 1'b0;
                  state <= S_SERVE_RD;
                end else begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end
              end
              KIND_CANCEL: begin
                q     <= 1'b1;
                state <= S_SCAN;
              end
              default: begin
                q     <= 1'b0;
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            pend_valid <= 1'b0;
            case (op_kind)
              KIND_ENQUEUE: begin
                res_status <= ST_DUP;
                state      <= S_DONE;
              end
              KIND_CANCEL: begin
                res_status <= ST_OK;
                res_id     <= JOB_ID_W'(key);
                res_fp     <= q;
                idx        <= CW'(pend_idx) + 1'b1;
                state      <= S_SHIFT;
              end
              default: begin
                res_status <= ST_OK;
                res_id     <= JOB_ID_W'(rd_id);
                res_pages  <= rd_pages;
                res_fp     <= q;
                state      <= S_DONE;
              end
            endcase
          end else if (idx_live) begin
            pend_valid <= 1'b1;
            pend_idx   <= idx[AW-1:0];
            idx        <= idx + 1'b1;
          end else if (!second) begin
            // First queue missed; the second one is scanned from its head.
            second     <= 1'b1;
            q          <= !q;
            idx        <= '0;
            pend_valid <= 1'b0;
          end else begin
            pend_valid <= 1'b0;
            state      <= S_DONE;
            if (op_kind == KIND_ENQUEUE) begin
              if (op_pages == '0) begin
                res_status <= ST_INVALID;
              end else if (tgt_fill == DEPTH_C) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_OK;
                if (op_prio) begin
                  prio_fill <= prio_fill + 1'b1;
                end else begin
                  norm_fill <= norm_fill + 1'b1;
                end
              end
            end else begin
              res_status <= ST_EMPTY;
            end
          end
        end
        S_SERVE_RD: begin
          state <= S_SERVE_CAP;
        end
        S_SERVE_CAP: begin
          res_status <= ST_OK;
          res_id     <= JOB_ID_W'(rd_id);
          res_pages  <= rd_pages;
          res_fp     <= q;
          idx        <= CW'(1);
          pend_valid <= 1'b0;
          state      <= S_SHIFT;
        end
        S_SHIFT: begin
          if (idx_live) begin
            pend_valid <= 1'b1;
            pend_idx   <= idx[AW-1:0];
            idx        <= idx + 1'b1;
          end else if (pend_valid) begin
            pend_valid <= 1'b0;
          end else begin
            if (q) begin
              prio_fill <= prio_fill - 1'b1;
            end else begin
              norm_fill <= norm_fill - 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(OUT_DATA_W - JOB_ID_W - PAGES_W - 1){1'b0}},
                         res_fp, res_pages, res_id};
            m_tuser  <= {{(OUT_USER_W - STATUS_W){1'b0}}, res_status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TCPQ_ASSERT_HOLDS(a_fill_bound, 1'b1, (prio_fill <= DEPTH_C) && (norm_fill <= DEPTH_C), "queue fill exceeds depth")
  `TCPQ_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_tready, "request accepted while busy")
  `TCPQ_ASSERT_HOLDS(a_one_fill_moves, prio_fill != $past(prio_fill), norm_fill == $past(norm_fill), "both fills changed at once")
  `TCPQ_ASSERT_HOLDS(a_scan_in_range, (state == S_SCAN) && pend_valid, CW'(pend_idx) < cur_fill, "compare on an entry beyond the fill")

endmodule

// ===== tb/two_class_priority_job_queue_top_test.sv =====
// Self-checking stream testbench for the two-class strict-priority job queue.
module two_class_priority_job_queue_top_test;
  import tcpq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int NORMAL_Q    = 0;
  localparam int PRIORITY_Q  = 1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [JOB_ID_W-1:0] id;
    logic [PAGES_W-1:0]  pages;
    logic                from_prio;
  } job_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  // Shadow copy of both queues, index NORMAL_Q or PRIORITY_Q, head at entry 0.
  logic [JOB_ID_W-1:0] job_ids[2][QUEUE_DEPTH];
  logic [PAGES_W-1:0]  job_pages[2][QUEUE_DEPTH];
  int                  job_fill[2] = '{0, 0};

  job_result_t expected_results[$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  two_class_priority_job_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS(16)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int find_job(input int cls, input logic [JOB_ID_W-1:0] id);
    for (int i = 0; i < job_fill[cls]; i++) begin
      if (job_ids[cls][i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void remove_job(input int cls, input int pos);
    for (int i = pos; i + 1 < job_fill[cls]; i++) begin
      job_ids[cls][i]   = job_ids[cls][i + 1];
      job_pages[cls][i] = job_pages[cls][i + 1];
    end
    job_fill[cls]--;
  endfunction

  // Applies one request to the shadow queues and returns the result (status, id, pages, class) it reports.
  function automatic job_result_t apply_job_request(input logic [KIND_W-1:0] op,
                                                    input logic [JOB_ID_W-1:0] id,
                                                    input logic [PAGES_W-1:0] pages,
                                                    input logic prio);
    job_result_t res;
    int          cls;
    int          pos;
    res = '0;
    res.status = ST_EMPTY;
    case (op)
      KIND_ENQUEUE: begin
        cls = prio ? PRIORITY_Q : NORMAL_Q;
        if (id == '0) begin
          res.status = ST_INVALID;
        end else if (find_job(PRIORITY_Q, id) >= 0 || find_job(NORMAL_Q, id) >= 0) begin
          res.status = ST_DUP;
        end else if (pages == '0) begin
          res.status = ST_INVALID;
        end else if (job_fill[cls] >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          job_ids[cls][job_fill[cls]]   = id;
          job_pages[cls][job_fill[cls]] = pages;
          job_fill[cls]++;
          res.status = ST_OK;
        end
      end
      KIND_SERVE: begin
        cls = (job_fill[PRIORITY_Q] > 0) ? PRIORITY_Q : NORMAL_Q;
        if (job_fill[cls] > 0) begin
          res.status    = ST_OK;
          res.id        = job_ids[cls][0];
          res.pages     = job_pages[cls][0];
          res.from_prio = (cls == PRIORITY_Q);
          remove_job(cls, 0);
        end
      end
      KIND_CANCEL: begin
        cls = PRIORITY_Q;
        pos = find_job(cls, id);
        if (pos < 0) begin
          cls = NORMAL_Q;
          pos = find_job(cls, id);
        end
        if (pos >= 0) begin
          res.status    = ST_OK;
          res.id        = id;
          res.from_prio = (cls == PRIORITY_Q);
          remove_job(cls, pos);
        end
      end
      default: begin
        // Lookup searches the normal queue before the priority queue.
        cls = NORMAL_Q;
        pos = find_job(cls, id);
        if (pos < 0) begin
          cls = PRIORITY_Q;
          pos = find_job(cls, id);
        end
        if (pos >= 0) begin
          res.status    = ST_OK;
          res.id        = job_ids[cls][pos];
          res.pages     = job_pages[cls][pos];
          res.from_prio = (cls == PRIORITY_Q);
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) $display("Mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      expected_results.push_back(apply_job_request(s_tuser[KIND_W-1:0],
                                                   s_tdata[15:0], s_tdata[31:16],
                                                   s_tdata[32]));
  end

  always @(posedge clk) begin
    job_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item, status %0d id %h",
                                  m_tuser[STATUS_W-1:0], m_tdata[15:0]));
      end else begin
        want = expected_results.pop_front();
        if (m_tuser[STATUS_W-1:0] !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    m_tuser[STATUS_W-1:0], want.status));
        if (m_tdata[15:0] !== want.id)
          report_mismatch($sformatf("out_id %h, expected %h", m_tdata[15:0], want.id));
        if (m_tdata[31:16] !== want.pages)
          report_mismatch($sformatf("out_pages %h, expected %h",
                                    m_tdata[31:16], want.pages));
        if (m_tdata[32] !== want.from_prio)
          report_mismatch($sformatf("from_priority %b, expected %b",
                                    m_tdata[32], want.from_prio));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Holds the item until accepted; tvalid stays high when the next item follows at once.
  task automatic send_job(input logic [KIND_W-1:0] op, input logic [JOB_ID_W-1:0] id,
                          input logic [PAGES_W-1:0] pages, input logic prio);
    int gap;
    s_tuser  <= {{(IN_USER_W-KIND_W){1'b0}}, op};
    s_tdata  <= {{(IN_DATA_W-33){1'b0}}, prio, pages, id};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drops tvalid so the last item is not sent again, then waits for every result.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [JOB_ID_W-1:0] pick_queued_id();
    int total;
    int idx;
    total = job_fill[PRIORITY_Q] + job_fill[NORMAL_Q];
    if (total == 0) return JOB_ID_W'($urandom_range(1, 96));
    idx = $urandom_range(total - 1);
    if (idx < job_fill[PRIORITY_Q]) return job_ids[PRIORITY_Q][idx];
    return job_ids[NORMAL_Q][idx - job_fill[PRIORITY_Q]];
  endfunction

  function automatic logic [JOB_ID_W-1:0] pick_enqueue_id();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 20) return pick_queued_id();
    if (r < 35) return JOB_ID_W'($urandom_range(65535));
    return JOB_ID_W'($urandom_range(1, 96));
  endfunction

  function automatic logic [JOB_ID_W-1:0] pick_search_id();
    int r;
    r = $urandom_range(99);
    if (r < 60) return pick_queued_id();
    if (r < 70) return '0;
    if (r < 85) return JOB_ID_W'($urandom_range(1, 96));
    return JOB_ID_W'($urandom_range(65535));
  endfunction

  function automatic logic [PAGES_W-1:0] pick_page_count();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return 16'hFFFF;
    return PAGES_W'($urandom_range(65535));
  endfunction

  task automatic test_directed_cases();
    send_idle_pct = 34;
    recv_idle_pct = 62;
    send_job(KIND_SERVE,   16'h0000, 16'h0000, 1'b0);
    send_job(KIND_CANCEL,  16'h0001, 16'h0000, 1'b0);
    send_job(KIND_LOOKUP,  16'hFFFF, 16'hFFFF, 1'b1);
    send_job(KIND_ENQUEUE, 16'h0000, 16'h0000, 1'b0);
    send_job(KIND_ENQUEUE, 16'h0000, 16'hFFFF, 1'b1);
    send_job(KIND_ENQUEUE, 16'hFFFF, 16'hFFFF, 1'b1);
    // The duplicate check comes before the page count check.
    send_job(KIND_ENQUEUE, 16'hFFFF, 16'h0000, 1'b0);
    send_job(KIND_ENQUEUE, 16'h0001, 16'h0000, 1'b0);
    send_job(KIND_ENQUEUE, 16'h0001, 16'h0001, 1'b0);
    send_job(KIND_ENQUEUE, 16'h8000, 16'h8000, 1'b0);
    send_job(KIND_ENQUEUE, 16'h00FF, 16'h7FFF, 1'b1);
    send_job(KIND_ENQUEUE, 16'h0001, 16'h1234, 1'b1);
    send_job(KIND_LOOKUP,  16'h0001, 16'h0000, 1'b0);
    send_job(KIND_LOOKUP,  16'hFFFF, 16'h0000, 1'b0);
    send_job(KIND_LOOKUP,  16'h0000, 16'h0000, 1'b0);
    send_job(KIND_CANCEL,  16'h0000, 16'h0000, 1'b0);
    send_job(KIND_CANCEL,  16'hFFFF, 16'h0000, 1'b0);
    send_job(KIND_CANCEL,  16'h0001, 16'h0000, 1'b0);
    send_job(KIND_CANCEL,  16'h0001, 16'h0000, 1'b0);
    send_job(KIND_SERVE,   16'h0000, 16'h0000, 1'b0);
    send_job(KIND_SERVE,   16'h0000, 16'h0000, 1'b0);
    send_job(KIND_SERVE,   16'h0000, 16'h0000, 1'b0);
    send_job(KIND_LOOKUP,  16'h8000, 16'h0000, 1'b1);
  endtask

  // Traffic in chunks of 40 items that alternately fill one class, drain, and mix.
  task automatic test_random_traffic(input int count, input int sender_pct,
                                     input int receiver_pct);
    int                  chunk_mode;
    int                  prio_bias;
    int                  r;
    logic [KIND_W-1:0]   op;
    chunk_mode = 0;
    prio_bias = 50;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        chunk_mode = (n / 40) % 3;
        prio_bias = $urandom_range(1) ? 85 : 15;
      end
      r = $urandom_range(99);
      case (chunk_mode)
        0: op = (r < 85) ? KIND_ENQUEUE : (r < 90) ? KIND_SERVE :
                (r < 95) ? KIND_CANCEL : KIND_LOOKUP;
        1: op = (r < 10) ? KIND_ENQUEUE : (r < 50) ? KIND_SERVE :
                (r < 80) ? KIND_CANCEL : KIND_LOOKUP;
        default: op = (r < 40) ? KIND_ENQUEUE : (r < 60) ? KIND_SERVE :
                      (r < 80) ? KIND_CANCEL : KIND_LOOKUP;
      endcase
      if (op == KIND_ENQUEUE) begin
        send_job(op, pick_enqueue_id(), pick_page_count(),
                 $urandom_range(99) < prio_bias);
      end else begin
        send_job(op, pick_search_id(), PAGES_W'($urandom_range(65535)),
                 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    wait_for_results();
    test_random_traffic(180, 34, 62);
    wait_for_results();
    test_random_traffic(180, 62, 34);
    test_random_traffic(170, 0, 0);
    wait_for_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
